[hw/rtl/stsi_pkg.sv]
// ----------------------------------------------------------------------------
// stsi_pkg
// Shared types and codes for the sorted table with insert and search.
// ----------------------------------------------------------------------------
`default_nettype none

package stsi_pkg;

   // Width of one stored value and of the reported position
   localparam int VALUE_W = 32;
   localparam int POS_W   = 6;

   // Item kinds
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_SEARCH = 1'b1;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_INSERTED = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_FOUND    = 2'd2,
      STATUS_MISSING  = 2'd3
   } status_type;

   // One result item
   typedef struct packed {
      status_type         status;
      logic [POS_W-1:0]   position;
   } result_type;

endpackage

`default_nettype wire

[hw/rtl/stsi_mem.sv]
// ----------------------------------------------------------------------------
// stsi_mem
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module stsi_mem #(
   parameter  int DEPTH  = 64,
   parameter  int WIDTH  = 32,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hw/rtl/stsi_engine.sv]
// ----------------------------------------------------------------------------
// stsi_engine
// Sequencer over the table RAM: top-down shift for insert, binary search.
// ----------------------------------------------------------------------------
`default_nettype none

module stsi_engine #(
   parameter int CAPACITY = 64
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic                              kind,
   input  wire logic signed [stsi_pkg::VALUE_W-1:0] value,
   input  wire logic                              out_free,
   output logic                                   idle,
   output logic                                   done,
   output stsi_pkg::result_type                   result
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (AW > stsi_pkg::POS_W) ? AW : stsi_pkg::POS_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_RD,
      S_INS_CMP,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_DONE
   } state_type;

   state_type                              state_ff, state_in;
   logic [CW-1:0]                          count_ff, count_in;
   logic signed [stsi_pkg::VALUE_W-1:0]    value_ff, value_in;
   logic [AW-1:0]                          idx_ff, idx_in;
   logic [CW-1:0]                          low_ff, low_in;
   logic [CW-1:0]                          high_ff, high_in;
   logic [AW-1:0]                          mid_ff, mid_in;
   stsi_pkg::result_type                   result_ff, result_in;

   // RAM ports
   logic                                   mem_we;
   logic [AW-1:0]                          mem_waddr;
   logic [stsi_pkg::VALUE_W-1:0]           mem_wdata;
   logic                                   mem_re;
   logic [AW-1:0]                          mem_raddr;
   logic signed [stsi_pkg::VALUE_W-1:0]    mem_rdata;

   // Helpers
   logic [CW-1:0]                          span;
   logic [CW-1:0]                          mid_sum;
   logic [PW-1:0]                          idx_wide;
   logic [PW-1:0]                          mid_wide;
   logic                                   ins_stop;

   stsi_mem #(
      .DEPTH (CAPACITY),
      .WIDTH (stsi_pkg::VALUE_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // Midpoint and index formatting
   always_comb begin
      span     = high_ff - low_ff;
      mid_sum  = low_ff + (span >> 1);
      idx_wide = PW'(idx_ff);
      mid_wide = PW'(mid_ff);
      // Entry 0 stays below an equal value; later entries only if strictly less
      if (idx_ff == AW'(1)) begin
         ins_stop = (mem_rdata <= value_ff);
      end else begin
         ins_stop = (mem_rdata < value_ff);
      end
   end

   // Next-state logic and RAM control
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      value_in  = value_ff;
      idx_in    = idx_ff;
      low_in    = low_ff;
      high_in   = high_ff;
      mid_in    = mid_ff;
      result_in = result_ff;
      mem_we    = 1'b0;
      mem_waddr = idx_ff;
      mem_wdata = value_ff;
      mem_re    = 1'b0;
      mem_raddr = idx_ff - AW'(1);

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               value_in = value;
               if (kind == stsi_pkg::KIND_INSERT) begin
                  if (count_ff == CW'(CAPACITY)) begin
                     result_in.status   = stsi_pkg::STATUS_FULL;
                     result_in.position = '0;
                     state_in           = S_DONE;
                  end else begin
                     idx_in   = count_ff[AW-1:0];
                     state_in = S_INS_RD;
                  end
               end else begin
                  low_in   = '0;
                  high_in  = count_ff;
                  state_in = S_SRCH_RD;
               end
            end
         end

         // Reached the bottom: value goes to slot 0, else fetch slot idx-1
         S_INS_RD: begin
            if (idx_ff == '0) begin
               mem_we             = 1'b1;
               mem_waddr          = '0;
               count_in           = count_ff + CW'(1);
               result_in.status   = stsi_pkg::STATUS_INSERTED;
               result_in.position = '0;
               state_in           = S_DONE;
            end else begin
               mem_re   = 1'b1;
               state_in = S_INS_CMP;
            end
         end

         // Either place the value at idx or move entry idx-1 up
         S_INS_CMP: begin
            mem_we = 1'b1;
            if (ins_stop) begin
               count_in           = count_ff + CW'(1);
               result_in.status   = stsi_pkg::STATUS_INSERTED;
               result_in.position = idx_wide[stsi_pkg::POS_W-1:0];
               state_in           = S_DONE;
            end else begin
               mem_wdata = mem_rdata;
               idx_in    = idx_ff - AW'(1);
               state_in  = S_INS_RD;
            end
         end

         S_SRCH_RD: begin
            if (low_ff < high_ff) begin
               mem_re    = 1'b1;
               mem_raddr = mid_sum[AW-1:0];
               mid_in    = mid_sum[AW-1:0];
               state_in  = S_SRCH_CMP;
            end else begin
               result_in.status   = stsi_pkg::STATUS_MISSING;
               result_in.position = '0;
               state_in           = S_DONE;
            end
         end

         S_SRCH_CMP: begin
            if (mem_rdata == value_ff) begin
               result_in.status   = stsi_pkg::STATUS_FOUND;
               result_in.position = mid_wide[stsi_pkg::POS_W-1:0];
               state_in           = S_DONE;
            end else if (mem_rdata < value_ff) begin
               low_in   = CW'(mid_ff) + CW'(1);
               state_in = S_SRCH_RD;
            end else begin
               high_in  = CW'(mid_ff);
               state_in = S_SRCH_RD;
            end
         end

         // Hold the result until the output register can take it
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      value_ff  <= value_in;
      idx_ff    <= idx_in;
      low_ff    <= low_in;
      high_ff   <= high_in;
      mid_ff    <= mid_in;
      result_ff <= result_in;
   end

   assign idle   = (state_ff == S_IDLE);
   assign done   = (state_ff == S_DONE) && out_free;
   assign result = result_ff;

endmodule

`default_nettype wire

[hw/rtl/sorted_table_insert_search.sv]
// ----------------------------------------------------------------------------
// sorted_table_insert_search
// Sorted table of signed 32-bit values with insert and binary search.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one item per command, req_kind selects insert or search,
//   req_value carries the value. rsp_ channel: one item per request, with
//   rsp_status and rsp_position.
//   Insert walks from the top of the table down, one entry at a time (RAM
//   read, then compare and write back). A search does one RAM read and one
//   compare per halving step. An insert into a full table goes straight to
//   its result without a RAM access. One item is in work at a time; the next
//   is taken in the cycle after the result is registered. Reset empties the
//   table at once (the count goes to zero; RAM contents are not cleared).
//   When rsp_ready is low the result sits in the output register and the
//   block still takes and works on the next item; it then waits with that
//   item's result until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_insert_search #(
   parameter int CAPACITY = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_kind,
   input  wire logic signed [stsi_pkg::VALUE_W-1:0] req_value,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [1:0]                               rsp_status,
   output logic [stsi_pkg::POS_W-1:0]               rsp_position
);

   logic                 eng_idle;
   logic                 eng_done;
   logic                 out_free;
   stsi_pkg::result_type eng_result;

   logic                 rsp_valid_ff, rsp_valid_in;
   stsi_pkg::result_type rsp_result_ff, rsp_result_in;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = eng_idle;

   stsi_engine #(
      .CAPACITY (CAPACITY)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .start    (req_valid && req_ready),
      .kind     (req_kind),
      .value    (req_value),
      .out_free (out_free),
      .idle     (eng_idle),
      .done     (eng_done),
      .result   (eng_result)
   );

   // Output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_result_in = rsp_result_ff;
      if (eng_done) begin
         rsp_valid_in  = 1'b1;
         rsp_result_in = eng_result;
      end else if (rsp_ready) begin
         rsp_valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_result_ff <= rsp_result_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_result_ff.status;
   assign rsp_position = rsp_result_ff.position;

endmodule

`default_nettype wire

[hw/rtl/stsi_checker.sv]
// ----------------------------------------------------------------------------
// stsi_checker
// Port-level checks for the sorted table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module stsi_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [1:0]                  rsp_status,
   input wire logic [stsi_pkg::POS_W-1:0]  rsp_position
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
                                   && $stable(rsp_position))
      else $error("stalled result item changed");

   // Full and not-found results carry position zero
   a_pos_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == stsi_pkg::STATUS_FULL ||
                    rsp_status == stsi_pkg::STATUS_MISSING)
      |-> rsp_position == '0)
      else $error("nonzero position on full or not-found result");

   // No result right out of reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result item valid after reset");

   // One item in work at a time: accepting an item closes the request side
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request ready right after an accepted item");

endmodule

bind sorted_table_insert_search stsi_checker u_stsi_checker (.*);

`default_nettype wire
